FILE: rtl/core/goal_settle_hold_tracker_core_assert.svh
// Assertion macros for the goal settle/hold tracker.
`ifndef GOAL_SETTLE_HOLD_TRACKER_CORE_ASSERT_SVH
`define GOAL_SETTLE_HOLD_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GSH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gsh_pkg.sv
package gsh_pkg;

  typedef enum logic [1:0] {
    PH_APPROACH = 2'd0,
    PH_SETTLE   = 2'd1,
    PH_HOLD     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_RECENTER = 2'd0,
    REG_FRAMES   = 2'd1,
    REG_TIME     = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_DW = 23;
  localparam int unsigned THR_NS_W = 36;
  localparam logic [19:0] NS_PER_MS = 20'd1_000_000;

  localparam logic [22:0]         RECENTER_RST = 23'd200;
  localparam logic [15:0]         FRAMES_RST   = 16'd5;
  localparam logic [THR_NS_W-1:0] THR_NS_RST   = 36'd200_000_000;

  localparam logic signed [24:0] EPS_POS_MM   = 25'sd50;
  localparam logic signed [24:0] EPS_NEG_MM   = -25'sd50;
  localparam logic signed [16:0] EPS_POS_MRAD = 17'sd50;
  localparam logic signed [16:0] EPS_NEG_MRAD = -17'sd50;
  localparam logic [15:0]        FRAMES_MAX   = 16'hFFFF;

  typedef struct packed {
    logic               pose_valid;
    logic [62:0]        stamp_ns;
    logic               target_valid;
    logic signed [23:0] target_x_mm;
    logic signed [23:0] target_y_mm;
    logic signed [15:0] target_yaw_mrad;
    logic               within_radius;
    logic               heading_ok;
    logic [22:0]        center_distance_mm;
  } in_item_t;

  typedef struct packed {
    phase_t      phase;
    logic        hold_mode;
    logic        reached;
    logic        is_settling;
    logic        drift_exit;
    logic [15:0] frames_in_window;
    logic [62:0] window_age_ns;
  } out_item_t;

  // Live configuration; the settle time is kept pre-scaled to ns.
  typedef struct packed {
    logic [22:0]         recenter_mm;
    logic [15:0]         frames;
    logic [THR_NS_W-1:0] thr_ns;
  } cfg_t;

endpackage

FILE: rtl/core/gsh_in_if.sv
interface gsh_in_if;
  import gsh_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/gsh_out_if.sv
interface gsh_out_if;
  import gsh_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/gsh_cfg.sv
module gsh_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [gsh_pkg::CFG_DW-1:0]     cfg_wdata,
  output gsh_pkg::cfg_t                  cfg
);
  import gsh_pkg::*;

  cfg_t                cfg_r;
  logic [THR_NS_W-1:0] thr_ns;

  // ms to ns scaling done once at write time
  assign thr_ns = THR_NS_W'(cfg_wdata[15:0]) * THR_NS_W'(NS_PER_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recenter_mm <= RECENTER_RST;
      cfg_r.frames      <= FRAMES_RST;
      cfg_r.thr_ns      <= THR_NS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_RECENTER: cfg_r.recenter_mm <= cfg_wdata;
        REG_FRAMES:   cfg_r.frames      <= cfg_wdata[15:0];
        REG_TIME:     cfg_r.thr_ns      <= thr_ns;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

FILE: rtl/core/gsh_track.sv
module gsh_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  gsh_pkg::in_item_t  item,
  input  gsh_pkg::cfg_t      cfg,
  output gsh_pkg::out_item_t res
);
  import gsh_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic               known_r, known_nxt;
  logic signed [23:0] last_x_r, last_x_nxt;
  logic signed [23:0] last_y_r, last_y_nxt;
  logic signed [15:0] last_yaw_r, last_yaw_nxt;
  logic [15:0]        frames_r, frames_nxt;
  logic [62:0]        entry_r, entry_nxt;

  logic signed [24:0] dx, dy;
  logic signed [16:0] dyaw;
  logic               moved, drift, in_win, frames_ok, time_ok, early;
  logic [15:0]        need;
  logic [63:0]        diff;
  logic [62:0]        elapsed;

  assign dx   = {item.target_x_mm[23], item.target_x_mm} - {last_x_r[23], last_x_r};
  assign dy   = {item.target_y_mm[23], item.target_y_mm} - {last_y_r[23], last_y_r};
  assign dyaw = {item.target_yaw_mrad[15], item.target_yaw_mrad}
              - {last_yaw_r[15], last_yaw_r};
  assign moved = !known_r ||
                 dx > EPS_POS_MM || dx < EPS_NEG_MM ||
                 dy > EPS_POS_MM || dy < EPS_NEG_MM ||
                 dyaw > EPS_POS_MRAD || dyaw < EPS_NEG_MRAD;
  assign in_win = item.within_radius && item.heading_ok;
  assign need   = (cfg.frames == '0) ? 16'd1 : cfg.frames;

  always_comb begin
    phase_nxt    = phase_r;
    known_nxt    = known_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    last_yaw_nxt = last_yaw_r;
    frames_nxt   = frames_r;
    entry_nxt    = entry_r;
    drift        = 1'b0;
    frames_ok    = 1'b0;
    time_ok      = 1'b0;

    if (moved) begin
      phase_nxt    = PH_APPROACH;
      known_nxt    = 1'b1;
      last_x_nxt   = item.target_x_mm;
      last_y_nxt   = item.target_y_mm;
      last_yaw_nxt = item.target_yaw_mrad;
      frames_nxt   = '0;
      entry_nxt    = '0;
    end

    if (phase_nxt == PH_HOLD && item.center_distance_mm > cfg.recenter_mm) begin
      drift      = 1'b1;
      phase_nxt  = PH_APPROACH;
      frames_nxt = '0;
      entry_nxt  = '0;
    end

    if (phase_nxt != PH_HOLD) begin
      if (in_win) begin
        if (frames_nxt == '0) entry_nxt = item.stamp_ns;
        if (frames_nxt != FRAMES_MAX) frames_nxt = frames_nxt + 16'd1;
      end else begin
        phase_nxt  = PH_APPROACH;
        frames_nxt = '0;
        entry_nxt  = '0;
      end
    end

    // borrow out of the 64-bit subtract flags a stamp before the entry
    diff  = {1'b0, item.stamp_ns} - {1'b0, entry_nxt};
    early = diff[63];

    if (phase_nxt != PH_HOLD && in_win) begin
      frames_ok = frames_nxt >= need;
      time_ok   = (cfg.thr_ns == '0) || (item.stamp_ns == '0) || (entry_nxt == '0) ||
                  (!early && diff[62:0] >= 63'(cfg.thr_ns));
      phase_nxt = (frames_ok && time_ok) ? PH_HOLD : PH_SETTLE;
    end

    elapsed = (entry_nxt != '0 && item.stamp_ns != '0 && !early) ? diff[62:0] : '0;

    // invalid pose or target wipes everything
    if (!item.pose_valid || !item.target_valid) begin
      phase_nxt    = PH_APPROACH;
      known_nxt    = 1'b0;
      last_x_nxt   = '0;
      last_y_nxt   = '0;
      last_yaw_nxt = '0;
      frames_nxt   = '0;
      entry_nxt    = '0;
      drift        = 1'b0;
      elapsed      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_APPROACH;
      known_r    <= 1'b0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      last_yaw_r <= '0;
      frames_r   <= '0;
      entry_r    <= '0;
    end else if (en) begin
      phase_r    <= phase_nxt;
      known_r    <= known_nxt;
      last_x_r   <= last_x_nxt;
      last_y_r   <= last_y_nxt;
      last_yaw_r <= last_yaw_nxt;
      frames_r   <= frames_nxt;
      entry_r    <= entry_nxt;
    end
  end

  assign res.phase            = phase_nxt;
  assign res.hold_mode        = (phase_nxt == PH_HOLD);
  assign res.reached          = (phase_nxt == PH_HOLD);
  assign res.is_settling      = (phase_nxt == PH_SETTLE);
  assign res.drift_exit       = drift;
  assign res.frames_in_window = frames_nxt;
  assign res.window_age_ns    = elapsed;
endmodule

FILE: rtl/core/goal_settle_hold_tracker_core.sv
// Channel   Dir  Handshake            Carries
// in_if     in   valid/ready          one pose update per transaction
// out_if    out  valid/ready          phase, flags, frame count, elapsed ns
// cfg_*     in   cfg_we, no back-pressure  register index + data
//
// Two stages: input register, then tracking logic feeding the result register.
// One transaction per cycle sustained while out_if.ready holds; both registers lie before out_if.valid.
// The tracker state updates in the cycle the input stage hands over to the result stage.
// A stalled out_if holds its result; the input register still takes one more transaction.
// rst_n is synchronous: clears both stages, tracker state and restores register defaults.
module goal_settle_hold_tracker_core (
  input  logic                       clk,
  input  logic                       rst_n,
  gsh_in_if.sink                     in_if,
  gsh_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [gsh_pkg::CFG_DW-1:0] cfg_wdata
);
  import gsh_pkg::*;

  `include "goal_settle_hold_tracker_core_assert.svh"

  cfg_t      cfg;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  logic      s1_adv;
  out_item_t res;
  out_item_t out_item_r;
  logic      out_valid_r;

  gsh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input stage moves on when the result register is free or being drained
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r <= in_if.data;
    end
  end

  // tracker state commits only on s1_adv, so each transaction is seen once
  gsh_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  // drift clears the window; at most the current frame is counted again
  `GSH_ASSERT_IMPLY(a_drift_restart,
                    out_valid_r && out_item_r.drift_exit,
                    out_item_r.frames_in_window <= 16'd1,
                    "drift result kept old window frames")
  // no window frames means no entry time, hence no elapsed time
  `GSH_ASSERT_IMPLY(a_elapsed_needs_window,
                    out_valid_r && out_item_r.frames_in_window == '0,
                    out_item_r.window_age_ns == '0,
                    "elapsed time without window frames")
  // a blocked input stage keeps its transaction
  `GSH_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r, "input stage lost a transaction")

endmodule

FILE: verif/gsh_tracker_checker.sv
module gsh_tracker_checker
  import gsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  gsh_in_if                 in_if,
  gsh_out_if                out_if,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int unsigned       fail_count,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // register shadows
  logic [22:0] thr_mm;
  logic [15:0] need_frames;
  logic [15:0] hold_ms;

  // tracker shadow
  phase_t             ph;
  logic               tgt_known;
  logic signed [23:0] tgt_x;
  logic signed [23:0] tgt_y;
  logic signed [15:0] tgt_yaw;
  logic [15:0]        win_frames;
  logic [62:0]        win_entry;

  out_item_t   expected_updates[$];
  int unsigned failures;

  function automatic void clear_tracker();
    ph         = PH_APPROACH;
    tgt_known  = 1'b0;
    tgt_x      = '0;
    tgt_y      = '0;
    tgt_yaw    = '0;
    win_frames = '0;
    win_entry  = '0;
  endfunction

  function automatic out_item_t step_tracker(in_item_t p);
    out_item_t   r;
    logic        drifted;
    logic        frames_ok;
    logic        time_ok;
    logic [15:0] need;
    int          dx;
    int          dy;
    int          dyaw;
    r       = '0;
    drifted = 1'b0;
    if (!p.pose_valid || !p.target_valid) begin
      clear_tracker();
      return r;
    end
    dx   = int'(p.target_x_mm) - int'(tgt_x);
    dy   = int'(p.target_y_mm) - int'(tgt_y);
    dyaw = int'(p.target_yaw_mrad) - int'(tgt_yaw);
    if (!tgt_known ||
        dx > int'(EPS_POS_MM) || dx < int'(EPS_NEG_MM) ||
        dy > int'(EPS_POS_MM) || dy < int'(EPS_NEG_MM) ||
        dyaw > int'(EPS_POS_MRAD) || dyaw < int'(EPS_NEG_MRAD)) begin
      ph         = PH_APPROACH;
      tgt_known  = 1'b1;
      tgt_x      = p.target_x_mm;
      tgt_y      = p.target_y_mm;
      tgt_yaw    = p.target_yaw_mrad;
      win_frames = '0;
      win_entry  = '0;
    end
    if (ph == PH_HOLD && p.center_distance_mm > thr_mm) begin
      drifted    = 1'b1;
      ph         = PH_APPROACH;
      win_frames = '0;
      win_entry  = '0;
    end
    if (ph != PH_HOLD) begin
      if (p.within_radius && p.heading_ok) begin
        need = (need_frames == '0) ? 16'd1 : need_frames;
        if (win_frames == '0) win_entry = p.stamp_ns;
        if (win_frames != FRAMES_MAX) win_frames = win_frames + 16'd1;
        frames_ok = (win_frames >= need);
        if (hold_ms == '0 || p.stamp_ns == '0 || win_entry == '0) begin
          time_ok = 1'b1;
        end else if (p.stamp_ns >= win_entry) begin
          time_ok = ((p.stamp_ns - win_entry) / 63'(NS_PER_MS)) >= 63'(hold_ms);
        end else begin
          time_ok = 1'b0;
        end
        ph = (frames_ok && time_ok) ? PH_HOLD : PH_SETTLE;
      end else begin
        ph         = PH_APPROACH;
        win_frames = '0;
        win_entry  = '0;
      end
    end
    r.phase            = ph;
    r.hold_mode        = (ph == PH_HOLD);
    r.reached          = (ph == PH_HOLD);
    r.is_settling      = (ph == PH_SETTLE);
    r.drift_exit       = drifted;
    r.frames_in_window = win_frames;
    if (win_entry != '0 && p.stamp_ns != '0 && p.stamp_ns >= win_entry)
      r.window_age_ns = p.stamp_ns - win_entry;
    return r;
  endfunction

  function automatic void check_update(out_item_t got);
    out_item_t want;
    if (expected_updates.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: result with nothing expected: phase %0d frames %0d", $realtime,
                 got.phase, got.frames_in_window);
      return;
    end
    want = expected_updates.pop_front();
    if (got.phase !== want.phase || got.hold_mode !== want.hold_mode ||
        got.reached !== want.reached || got.is_settling !== want.is_settling ||
        got.drift_exit !== want.drift_exit ||
        got.frames_in_window !== want.frames_in_window ||
        got.window_age_ns !== want.window_age_ns) begin
      failures++;
      if (failures <= 10)
        $display({"%0t: mismatch exp/act: phase %0d/%0d hold %0b/%0b reached %0b/%0b",
                  " settling %0b/%0b drift %0b/%0b frames %0d/%0d elapsed %0d/%0d"},
                 $realtime, want.phase, got.phase, want.hold_mode, got.hold_mode,
                 want.reached, got.reached, want.is_settling, got.is_settling,
                 want.drift_exit, got.drift_exit,
                 want.frames_in_window, got.frames_in_window,
                 want.window_age_ns, got.window_age_ns);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_mm      = RECENTER_RST;
      need_frames = FRAMES_RST;
      hold_ms     = 16'd200;
      clear_tracker();
      expected_updates.delete();
      failures    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_RECENTER: thr_mm      = cfg_wdata[22:0];
          REG_FRAMES:   need_frames = cfg_wdata[15:0];
          REG_TIME:     hold_ms     = cfg_wdata[15:0];
          default: ;
        endcase
      end
      // results first, so a same-edge transaction on the input is never paired with them
      if (out_if.valid && out_if.ready) check_update(out_if.data);
      if (in_if.valid && in_if.ready) expected_updates.push_back(step_tracker(in_if.data));
    end
    outstanding <= expected_updates.size();
    fail_count  <= failures;
  end

endmodule

FILE: verif/tb_goal_settle_hold_tracker_core.sv
module tb_goal_settle_hold_tracker_core
  import gsh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Any quiet stretch is bounded by the longest result stall, the longest input
  // gap, a four-write register burst and the two-stage pipe.
  localparam int unsigned IDLE_LIMIT       = 1000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned RAND_PER_SETTING = 220;
  localparam logic [1:0]  REG_UNUSED       = 2'd3;
  localparam logic [22:0] CFG_MAX          = 23'h7FFFFF;
  localparam logic [62:0] STAMP_MAX        = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] T0               = 63'd1_000_000_000;
  localparam logic [62:0] MS               = 63'd1_000_000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  int unsigned       fail_count;
  int unsigned       outstanding;
  int unsigned       idle_cycles;
  int unsigned       poses_sent;

  // What has been programmed, so the stimulus can aim at the interesting edges.
  logic [22:0] thr_mm;
  logic [15:0] need_frames;
  logic [15:0] hold_ms;

  gsh_in_if  in_ch ();
  gsh_out_if out_ch ();

  goal_settle_hold_tracker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  gsh_tracker_checker tracker_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length shared by both sides: mostly none, otherwise a short one or,
  // now and then, a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Spread over the whole 63-bit range, shifted so small stamps turn up too.
  function automatic logic [62:0] rand_stamp();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[62:0] >> $urandom_range(0, 62);
  endfunction

  // Target jitter: mostly inside the 50 mm / 50 mrad dead band, sometimes just out.
  function automatic int wobble();
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 1) return 51 + int'($urandom_range(0, 9));
      return -51 - int'($urandom_range(0, 9));
    end
    return int'($urandom_range(0, 100)) - 50;
  endfunction

  // Distances that straddle the recentre threshold, with the odd wild one.
  function automatic logic [22:0] near_thr();
    int d;
    if ($urandom_range(0, 4) == 0) return 23'($urandom);
    d = int'(thr_mm) + int'($urandom_range(0, 4)) - 2;
    if (d < 0) d = 0;
    if (d > int'(CFG_MAX)) d = int'(CFG_MAX);
    return 23'(d);
  endfunction

  function automatic in_item_t noise_pose();
    in_item_t p;
    p.pose_valid         = ($urandom_range(0, 4) != 0);
    p.stamp_ns           = rand_stamp();
    p.target_valid       = ($urandom_range(0, 4) != 0);
    p.target_x_mm        = 24'($urandom);
    p.target_y_mm        = 24'($urandom);
    p.target_yaw_mrad    = 16'($urandom);
    p.within_radius      = 1'($urandom_range(0, 1));
    p.heading_ok         = 1'($urandom_range(0, 1));
    p.center_distance_mm = 23'($urandom);
    return p;
  endfunction

  // One transaction on the pose channel. A gap, if any, comes before valid is
  // raised, so valid never drops and rises in the same step.
  task automatic send_pose(in_item_t p);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= p;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    poses_sent++;
  endtask

  task automatic send_valid_pose(logic [62:0] st, logic signed [23:0] x,
                                 logic signed [23:0] y, logic signed [15:0] yaw,
                                 logic wr, logic ya, logic [22:0] ctr_dist);
    in_item_t p;
    p.pose_valid         = 1'b1;
    p.stamp_ns           = st;
    p.target_valid       = 1'b1;
    p.target_x_mm        = x;
    p.target_y_mm        = y;
    p.target_yaw_mrad    = yaw;
    p.within_radius      = wr;
    p.heading_ok         = ya;
    p.center_distance_mm = ctr_dist;
    send_pose(p);
  endtask

  // Stop feeding and wait until every result is back. The first edge is
  // needed so that a transaction taken this very edge shows up in the count.
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Register burst on an idle block, plus a poke at the unmapped index,
  // which must leave everything alone.
  task automatic program_regs(logic [22:0] thr, logic [22:0] frames, logic [22:0] ms);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_RECENTER;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_addr  <= REG_FRAMES;
    cfg_wdata <= frames;
    @(posedge clk);
    cfg_addr  <= REG_TIME;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_addr  <= REG_UNUSED;
    cfg_wdata <= 23'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_mm      = thr;
    need_frames = frames[15:0];
    hold_ms     = ms[15:0];
  endtask

  // A well-formed approach: a few frames outside the window, then the frame target
  // (at most ten) plus up to two in the window, then some hold frames near the drift
  // limit. Stamps step so that the settle time lands around the frame target; a few
  // frames carry a zero stamp or step backwards.
  task automatic run_episode();
    int unsigned        n_out;
    int unsigned        n_in;
    int unsigned        n_hold;
    int unsigned        nf;
    int unsigned        roll;
    logic [63:0]        per;
    logic [62:0]        st;
    logic [62:0]        st_k;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [15:0] byaw;
    logic               wr;
    logic               ya;
    bx   = 24'($urandom);
    by   = 24'($urandom);
    byaw = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      // keep most goals in a modest area so neighbouring episodes sometimes match
      bx   = 24'(int'($urandom_range(0, 2000)) - 1000);
      by   = 24'(int'($urandom_range(0, 2000)) - 1000);
      byaw = 16'(int'($urandom_range(0, 600)) - 300);
    end
    nf     = (need_frames == '0) ? 1 : int'(need_frames);
    per    = (64'(hold_ms) * 64'd1_000_000) / 64'(nf);
    per    = per * 64'($urandom_range(5, 20)) / 64'd10 + 64'($urandom_range(0, 999));
    st     = rand_stamp();
    n_out  = $urandom_range(0, 2);
    n_in   = ((nf > 10) ? 10 : nf) + $urandom_range(0, 2);
    n_hold = $urandom_range(0, 6);
    for (int unsigned k = 0; k < n_out + n_in + n_hold; k++) begin
      st   = st + per[62:0];
      st_k = st;
      roll = $urandom_range(0, 99);
      if (roll < 4) st_k = '0;
      else if (roll < 7) st_k = st - per[62:0] - 63'd1;
      wr = 1'b1;
      ya = 1'b1;
      if (k < n_out || $urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: wr = 1'b0;
          1: ya = 1'b0;
          default: begin
            wr = 1'b0;
            ya = 1'b0;
          end
        endcase
      end
      if (k == 0)
        send_valid_pose(st_k, bx, by, byaw, wr, ya, near_thr());
      else
        send_valid_pose(st_k, bx + 24'(wobble()), by + 24'(wobble()),
                        byaw + 16'(wobble()), wr, ya, near_thr());
    end
  endtask

  // Mostly well-formed approaches, the rest short bursts of anything at all.
  task automatic random_run(int unsigned budget);
    int unsigned start;
    start = poses_sent;
    while (poses_sent - start < budget) begin
      if ($urandom_range(0, 3) != 0) begin
        run_episode();
      end else begin
        repeat ($urandom_range(1, 3)) send_pose(noise_pose());
      end
    end
  endtask

  // Result side back-pressure: ready runs of varying length, then now and then a stall.
  initial begin : result_backpressure
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      stall = idle_len();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog: a long run of edges with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** goal_settle_hold_tracker_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t p;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_addr    <= REG_RECENTER;
    cfg_wdata   <= '0;
    poses_sent  = 0;
    thr_mm      = RECENTER_RST;
    need_frames = FRAMES_RST;
    hold_ms     = 16'd200;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, reset register values (200 mm, 5 frames, 200 ms) ----
    // invalid pose, then invalid target, with every other bit set
    p = '1;
    p.pose_valid = 1'b0;
    send_pose(p);
    p = '1;
    p.target_valid = 1'b0;
    send_pose(p);
    // first target ever, at the coordinate extremes: always a change
    send_valid_pose(T0, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 1'b1, 1'b1, 23'd0);
    // jitter of exactly 50 on each axis is not a change
    send_valid_pose(T0 + 50 * MS, 24'sh7FFFCD, 24'sh800000, 16'sh7FFF, 1'b1, 1'b1, 23'd5);
    send_valid_pose(T0 + 100 * MS, 24'sh7FFFFF, 24'sh800032, 16'sh7FFF, 1'b1, 1'b1, 23'd5);
    send_valid_pose(T0 + 150 * MS, 24'sh7FFFFF, 24'sh800000, 16'sh7FCD, 1'b1, 1'b1, 23'd5);
    // fifth frame, 200 ms in: both conditions met, into hold
    send_valid_pose(T0 + 200 * MS, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 1'b1, 1'b1, 23'd0);
    // in hold the window flags do not matter; distance right at the threshold holds
    send_valid_pose(T0 + 250 * MS, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 1'b0, 1'b0, 23'd200);
    // one past the threshold: drift, and a fresh window starts on the same frame
    send_valid_pose(T0 + 300 * MS, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 1'b1, 1'b1, 23'd201);
    // 51 mm move restarts the approach
    send_valid_pose(T0 + 350 * MS, 24'sh7FFFCC, 24'sh800000, 16'sh7FFF, 1'b1, 1'b1, 23'd0);
    // zero stamps skip the time check: hold on the fifth frame
    repeat (4) send_valid_pose('0, 24'sh7FFFCC, 24'sh800000, 16'sh7FFF, 1'b1, 1'b1, 23'd0);
    // 51 mrad yaw move, then a stamp before the window entry
    send_valid_pose(T0 + 1000 * MS, 24'sh7FFFCC, 24'sh800000, 16'sh7FCC, 1'b1, 1'b1, 23'd0);
    send_valid_pose(T0 + 1000 * MS - 63'd1, 24'sh7FFFCC, 24'sh800000, 16'sh7FCC,
                    1'b1, 1'b1, 23'd0);
    // yaw no longer aligned: window left, frame count and entry cleared
    send_valid_pose(T0 + 1010 * MS, 24'sh7FFFCC, 24'sh800000, 16'sh7FCC, 1'b1, 1'b0, 23'd0);
    // opposite extremes, largest stamp and distance
    send_valid_pose(STAMP_MAX, 24'sh800000, 24'sh7FFFFF, 16'sh8000, 1'b1, 1'b1, CFG_MAX);
    send_valid_pose(STAMP_MAX, 24'sh800000, 24'sh7FFFFF, 16'sh8000, 1'b0, 1'b1, CFG_MAX);
    send_pose('0);
    random_run(RAND_PER_SETTING);

    // ---- lowest settings: one frame, no time check, zero drift allowance ----
    program_regs('0, '0, '0);
    send_valid_pose(63'd777, 24'sd0, 24'sd0, 16'sd0, 1'b1, 1'b1, 23'd0);
    // drift out of hold and straight back in on the same transaction
    send_valid_pose(63'd788, 24'sd0, 24'sd0, 16'sd0, 1'b1, 1'b1, 23'd1);
    send_valid_pose(63'd799, 24'sd0, 24'sd0, 16'sd0, 1'b0, 1'b0, 23'd0);
    random_run(RAND_PER_SETTING);

    // ---- highest settings; junk in the upper data bits of the 16-bit registers ----
    program_regs(CFG_MAX, CFG_MAX, CFG_MAX);
    random_run(RAND_PER_SETTING);

    // ---- two random settings, the first mid-range ----
    program_regs(23'($urandom_range(0, 500)), 23'($urandom_range(1, 6)),
                 23'($urandom_range(1, 300)));
    random_run(RAND_PER_SETTING);
    program_regs(23'($urandom), 23'($urandom_range(0, 3)), 23'($urandom_range(0, 20)));
    random_run(RAND_PER_SETTING);

    // ---- drain and verdict ----
    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** goal_settle_hold_tracker_core: PASSED **");
    end else begin
      $display("** goal_settle_hold_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule
